[rtl/ipcv_pkg.sv]
package ipcv_pkg;

  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned MAX_SLOTS    = 12;
  localparam logic [20:0] COUNT_MAX    = 21'h1FFFFF;
  localparam logic [31:0] COORD_POS    = 32'd1000000;
  localparam logic [31:0] COORD_NEG    = 32'hFFF0BDC0;
  localparam logic [31:0] DIM_MAX      = 32'd32768;
  localparam logic [31:0] SCALE_MIN    = 32'd50;
  localparam logic [31:0] SCALE_MAX    = 32'd400;

  typedef enum logic [2:0] {
    CFG_VERSION   = 3'd0,
    CFG_MAX_FRAME = 3'd1,
    CFG_MAX_SRCH  = 3'd2,
    CFG_MAX_SEL   = 3'd3,
    CFG_MAX_KIND  = 3'd4,
    CFG_SRCH_KIND = 3'd5,
    CFG_MAX_RSN   = 3'd6,
    CFG_MAX_LOC   = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ERR_NONE     = 4'd0,
    ERR_SMALL    = 4'd1,
    ERR_LARGE    = 4'd2,
    ERR_MAGIC    = 4'd3,
    ERR_VERSION  = 4'd4,
    ERR_TYPE     = 4'd5,
    ERR_RESERVED = 4'd6,
    ERR_SIZE     = 4'd7,
    ERR_MALFORM  = 4'd8,
    ERR_RANGE    = 4'd9,
    ERR_UTF8     = 4'd10
  } err_code_t;

  typedef enum logic [2:0] {
    FT_END  = 3'd0,
    FT_TXN  = 3'd1,
    FT_TEXT = 3'd2,
    FT_U8   = 3'd3,
    FT_U16  = 3'd4,
    FT_U32  = 3'd5,
    FT_U64  = 3'd6
  } ftype_t;

  typedef enum logic [3:0] {
    CK_NONE   = 4'd0,
    CK_MIN    = 4'd1,
    CK_MAX    = 4'd2,
    CK_NZ     = 4'd3,
    CK_COORD  = 4'd4,
    CK_DIM    = 4'd5,
    CK_LOCALE = 4'd6,
    CK_SCALE  = 4'd7,
    CK_BOOL   = 4'd8,
    CK_KIND   = 4'd9,
    CK_REASON = 4'd10,
    CK_SEARCH = 4'd11,
    CK_SELECT = 4'd12
  } check_t;

  typedef struct packed {
    ftype_t ft;
    check_t ck;
  } slot_t;

  typedef enum logic [3:0] {
    U_LEAD  = 4'd0,
    U_NEED1 = 4'd1,
    U_NEED2 = 4'd2,
    U_NEED3 = 4'd3,
    U_E0    = 4'd4,
    U_ED    = 4'd5,
    U_F0    = 4'd6,
    U_F4    = 4'd7,
    U_BAD   = 4'd8
  } utf8_t;

  typedef struct packed {
    logic magic;
    logic version;
    logic mtype;
    logic reserved;
    logic overflow;
    logic trail;
    logic fail;
    logic txt_range;
    logic txt_utf8;
  } err_flags_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] i);
    logic [7:0] r;
    case (i)
      2'd0:    r = 8'h45;
      2'd1:    r = 8'h50;
      2'd2:    r = 8'h41;
      default: r = 8'h4C;
    endcase
    return r;
  endfunction

  function automatic slot_t slot_entry(input logic [3:0] kind, input logic [3:0] slot);
    slot_t r;
    r = '{ft: FT_END, ck: CK_NONE};
    case (kind)
      4'd1: begin
        case (slot)
          4'd0:    r = '{ft: FT_U16, ck: CK_MIN};
          4'd1:    r = '{ft: FT_U16, ck: CK_MAX};
          4'd2:    r = '{ft: FT_U64, ck: CK_NONE};
          4'd3:    r = '{ft: FT_U32, ck: CK_NONE};
          default: r = '{ft: FT_END, ck: CK_NONE};
        endcase
      end
      4'd2: begin
        case (slot)
          4'd0:    r = '{ft: FT_U16, ck: CK_NZ};
          4'd1:    r = '{ft: FT_U64, ck: CK_NONE};
          4'd2:    r = '{ft: FT_U32, ck: CK_NONE};
          default: r = '{ft: FT_END, ck: CK_NONE};
        endcase
      end
      4'd3: begin
        case (slot)
          4'd0:    r = '{ft: FT_TXN, ck: CK_NONE};
          4'd1, 4'd2, 4'd5, 4'd6: r = '{ft: FT_U32, ck: CK_COORD};
          4'd3, 4'd4, 4'd7, 4'd8: r = '{ft: FT_U32, ck: CK_DIM};
          4'd9:    r = '{ft: FT_U8, ck: CK_LOCALE};
          4'd10:   r = '{ft: FT_U16, ck: CK_SCALE};
          4'd11:   r = '{ft: FT_U8, ck: CK_BOOL};
          default: r = '{ft: FT_END, ck: CK_NONE};
        endcase
      end
      4'd4: begin
        case (slot)
          4'd0:    r = '{ft: FT_TXN, ck: CK_NONE};
          4'd1:    r = '{ft: FT_U32, ck: CK_NONE};
          4'd2:    r = '{ft: FT_U8, ck: CK_KIND};
          4'd3:    r = '{ft: FT_TEXT, ck: CK_SEARCH};
          default: r = '{ft: FT_END, ck: CK_NONE};
        endcase
      end
      4'd5, 4'd7: begin
        case (slot)
          4'd0:    r = '{ft: FT_TXN, ck: CK_NONE};
          4'd1:    r = '{ft: FT_U8, ck: CK_REASON};
          default: r = '{ft: FT_END, ck: CK_NONE};
        endcase
      end
      4'd6: begin
        case (slot)
          4'd0:    r = '{ft: FT_TXN, ck: CK_NONE};
          4'd1:    r = '{ft: FT_TEXT, ck: CK_SELECT};
          default: r = '{ft: FT_END, ck: CK_NONE};
        endcase
      end
      4'd8, 4'd9: begin
        case (slot)
          4'd0:    r = '{ft: FT_U64, ck: CK_NONE};
          default: r = '{ft: FT_END, ck: CK_NONE};
        endcase
      end
      default: r = '{ft: FT_END, ck: CK_NONE};
    endcase
    return r;
  endfunction

  function automatic utf8_t utf8_next(input utf8_t s, input logic [7:0] b);
    logic  cont;
    utf8_t r;
    cont = (b[7:6] == 2'b10);
    case (s)
      U_LEAD: begin
        if (b < 8'h80) r = U_LEAD;
        else if (b inside {[8'hC2:8'hDF]}) r = U_NEED1;
        else if (b == 8'hE0) r = U_E0;
        else if (b == 8'hED) r = U_ED;
        else if (b inside {[8'hE1:8'hEF]}) r = U_NEED2;
        else if (b == 8'hF0) r = U_F0;
        else if (b == 8'hF4) r = U_F4;
        else if (b inside {[8'hF1:8'hF3]}) r = U_NEED3;
        else r = U_BAD;
      end
      U_NEED1: r = cont ? U_LEAD : U_BAD;
      U_NEED2: r = cont ? U_NEED1 : U_BAD;
      U_NEED3: r = cont ? U_NEED2 : U_BAD;
      U_E0:    r = (b inside {[8'hA0:8'hBF]}) ? U_NEED1 : U_BAD;
      U_ED:    r = (b inside {[8'h80:8'h9F]}) ? U_NEED1 : U_BAD;
      U_F0:    r = (b inside {[8'h90:8'hBF]}) ? U_NEED2 : U_BAD;
      U_F4:    r = (b inside {[8'h80:8'h8F]}) ? U_NEED2 : U_BAD;
      default: r = U_BAD;
    endcase
    return r;
  endfunction

endpackage

[rtl/ipcv_in_if.sv]
interface ipcv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, data_byte, frame_end, input ready);
  modport sink (input valid, data_byte, frame_end, output ready);
endinterface

[rtl/ipcv_out_if.sv]
interface ipcv_out_if;
  logic        valid;
  logic        ready;
  logic        frame_ok;
  logic [3:0]  error_code;
  logic [3:0]  message_kind;
  logic [20:0] payload_bytes;

  modport source (output valid, frame_ok, error_code, message_kind, payload_bytes,
                  input ready);
  modport sink (input valid, frame_ok, error_code, message_kind, payload_bytes,
                output ready);
endinterface

[rtl/ipc_frame_validator_unit.sv]
// Frame validator for framed inter-process messages.
// in_ch carries one frame byte per word with frame_end set on the last byte.
// The first 12 bytes are the header (magic, version, type, reserved, length);
// the payload is then parsed field by field for the header's message type.
// out_ch carries one verdict word per frame: frame_ok, the highest-priority error
// code, the message kind and the payload byte count (saturated).
// Throughput: one byte per cycle unless a pending verdict stalls; every byte
// is taken by one combinational step between the frame state and result registers.
// Latency: the verdict appears on out_ch the cycle after the last byte.
// The result register is the only output storage: when the receiver stalls
// with a verdict pending, in_ch.ready drops until that verdict is taken.
// Configuration writes go through cfg_we/cfg_idx/cfg_wdata and must happen
// between frames. Reset restores the register defaults and clears the frame
// state; no clearing pass is needed.
module ipc_frame_validator_unit
  import ipcv_pkg::*;
#(
  parameter int unsigned ID_BYTES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  ipcv_in_if.sink           in_ch,
  ipcv_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_idx,
  input  logic [20:0]       cfg_wdata
);

  localparam int unsigned MAX_FLD = (ID_BYTES > 8) ? ID_BYTES : 8;
  localparam int unsigned IDX_W   = $clog2(MAX_FLD + 1);

  logic [15:0] ver_r;
  logic [20:0] max_frame_r;
  logic [15:0] max_srch_r;
  logic [15:0] max_sel_r;
  logic [7:0]  max_kind_r;
  logic [7:0]  srch_kind_r;
  logic [7:0]  max_rsn_r;
  logic [7:0]  max_loc_r;

  logic [20:0]      cnt_r, cnt_nxt;
  logic [3:0]       slot_r, slot_nxt;
  logic             done_r, done_nxt;
  logic [IDX_W-1:0] fidx_r, fidx_nxt;
  logic [31:0]      acc_r, acc_nxt;
  logic [31:0]      dlen_r, dlen_nxt;
  logic [3:0]       kind_r, kind_nxt;
  logic [15:0]      trem_r, trem_nxt;
  utf8_t            u8s_r, u8s_nxt;
  logic             idnz_r, idnz_nxt;
  err_flags_t       flg_r, flg_nxt;
  logic [15:0]      saved_r, saved_nxt;

  logic        out_valid_r;
  logic        out_ok_r;
  err_code_t   out_code_r;
  logic [3:0]  out_kind_r;
  logic [20:0] out_bytes_r;

  logic        in_acc;
  logic        last_acc;
  err_code_t   code_c;
  logic [20:0] bytes_c;

  function automatic logic [IDX_W-1:0] fsize(input ftype_t t);
    logic [IDX_W-1:0] r;
    case (t)
      FT_TXN:  r = IDX_W'(ID_BYTES);
      FT_U8:   r = IDX_W'(1);
      FT_U16:  r = IDX_W'(2);
      FT_TEXT: r = IDX_W'(2);
      FT_U32:  r = IDX_W'(4);
      default: r = IDX_W'(8);
    endcase
    return r;
  endfunction

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign last_acc    = in_acc && in_ch.frame_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ver_r       <= 16'd1;
      max_frame_r <= 21'd65536;
      max_srch_r  <= 16'd256;
      max_sel_r   <= 16'd256;
      max_kind_r  <= 8'd7;
      srch_kind_r <= 8'd0;
      max_rsn_r   <= 8'd3;
      max_loc_r   <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_VERSION:   ver_r       <= cfg_wdata[15:0];
        CFG_MAX_FRAME: max_frame_r <= cfg_wdata;
        CFG_MAX_SRCH:  max_srch_r  <= cfg_wdata[15:0];
        CFG_MAX_SEL:   max_sel_r   <= cfg_wdata[15:0];
        CFG_MAX_KIND:  max_kind_r  <= cfg_wdata[7:0];
        CFG_SRCH_KIND: srch_kind_r <= cfg_wdata[7:0];
        CFG_MAX_RSN:   max_rsn_r   <= cfg_wdata[7:0];
        CFG_MAX_LOC:   max_loc_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [7:0]       b;
    logic             hdr;
    logic [3:0]       hidx;
    logic [31:0]      base;
    logic [31:0]      consumed;
    logic [31:0]      rem;
    logic [31:0]      acc_sh;
    logic             f_txn, f_1, f_2, f_4, f_8;
    logic             enter;
    logic [3:0]       start;
    logic             found;
    logic             fits;
    slot_t            cur;
    slot_t            se;
    logic [IDX_W-1:0] fidx_inc;
    logic [15:0]      len;
    logic [15:0]      lim;
    logic [15:0]      trem_dec;
    utf8_t            u8n;

    b         = in_ch.data_byte;
    cnt_nxt   = cnt_r;
    slot_nxt  = slot_r;
    done_nxt  = done_r;
    fidx_nxt  = fidx_r;
    acc_nxt   = acc_r;
    dlen_nxt  = dlen_r;
    kind_nxt  = kind_r;
    trem_nxt  = trem_r;
    u8s_nxt   = u8s_r;
    idnz_nxt  = idnz_r;
    flg_nxt   = flg_r;
    saved_nxt = saved_r;
    enter     = 1'b0;
    start     = 4'd0;
    found     = 1'b0;
    fits      = 1'b0;
    len       = 16'd0;
    lim       = 16'd0;
    trem_dec  = 16'd0;
    u8n       = U_LEAD;
    se        = '{ft: FT_END, ck: CK_NONE};

    hdr      = (cnt_r < 21'(HEADER_BYTES));
    hidx     = cnt_r[3:0];
    acc_sh   = {acc_r[23:0], b};
    base     = hdr ? acc_sh : dlen_r;
    consumed = hdr ? 32'd0 : {11'd0, cnt_r - 21'(HEADER_BYTES - 1)};
    rem      = (base > consumed) ? base - consumed : 32'd0;
    f_txn    = rem >= 32'(ID_BYTES);
    f_1      = rem >= 32'd1;
    f_2      = rem >= 32'd2;
    f_4      = rem >= 32'd4;
    f_8      = rem >= 32'd8;
    cur      = slot_entry(kind_r, slot_r - 4'd1);
    fidx_inc = fidx_r + IDX_W'(1);

    if (cnt_r == COUNT_MAX) begin
      flg_nxt.overflow = 1'b1;
    end else begin
      cnt_nxt = cnt_r + 21'd1;
      if (hdr) begin
        case (hidx)
          4'd0, 4'd1, 4'd2, 4'd3: begin
            if (b != magic_byte(hidx[1:0])) flg_nxt.magic = 1'b1;
          end
          4'd4: acc_nxt = acc_sh;
          4'd5: begin
            if (acc_sh[15:0] != ver_r) flg_nxt.version = 1'b1;
            acc_nxt = 32'd0;
          end
          4'd6: begin
            if (b >= 8'd1 && b <= 8'd9) begin
              kind_nxt = b[3:0];
            end else begin
              kind_nxt = 4'd0;
              flg_nxt.mtype = 1'b1;
            end
          end
          4'd7: begin
            if (b != 8'd0) flg_nxt.reserved = 1'b1;
          end
          4'd11: begin
            dlen_nxt = acc_sh;
            acc_nxt  = 32'd0;
            if (kind_r != 4'd0) begin
              enter = 1'b1;
              start = 4'd0;
            end else begin
              done_nxt = 1'b1;
            end
          end
          default: acc_nxt = acc_sh;
        endcase
      end else if (done_r) begin
        flg_nxt.trail = 1'b1;
      end else if (cur.ft == FT_TEXT) begin
        start = slot_r;
        if (fidx_r < IDX_W'(2)) begin
          acc_nxt  = acc_sh;
          fidx_nxt = fidx_inc;
          if (fidx_inc == IDX_W'(2)) begin
            len = acc_sh[15:0];
            lim = (cur.ck == CK_SEARCH) ? max_srch_r : max_sel_r;
            if (len > lim || {16'd0, len} > rem) begin
              flg_nxt.fail      = 1'b1;
              flg_nxt.txt_range = 1'b1;
              enter             = 1'b1;
            end else begin
              if (cur.ck == CK_SEARCH && len != 16'd0 && saved_r != {8'd0, srch_kind_r})
                flg_nxt.fail = 1'b1;
              if (cur.ck == CK_SELECT && len == 16'd0) flg_nxt.fail = 1'b1;
              if (len == 16'd0) enter = 1'b1;
              else trem_nxt = len;
            end
          end
        end else begin
          u8n      = utf8_next(u8s_r, b);
          u8s_nxt  = u8n;
          trem_dec = (trem_r != 16'd0) ? trem_r - 16'd1 : trem_r;
          trem_nxt = trem_dec;
          if (trem_dec == 16'd0) begin
            if (u8n != U_LEAD) begin
              flg_nxt.fail     = 1'b1;
              flg_nxt.txt_utf8 = 1'b1;
            end
            enter = 1'b1;
          end
        end
      end else begin
        start    = slot_r;
        acc_nxt  = acc_sh;
        if (b != 8'd0) idnz_nxt = 1'b1;
        fidx_nxt = fidx_inc;
        if (fidx_inc >= fsize(cur.ft)) begin
          enter = 1'b1;
          case (cur.ck)
            CK_MIN: begin
              if (acc_sh == 32'd0) flg_nxt.fail = 1'b1;
              saved_nxt = acc_sh[15:0];
            end
            CK_MAX: begin
              if ({16'd0, saved_r} > acc_sh) flg_nxt.fail = 1'b1;
            end
            CK_NZ: begin
              if (acc_sh == 32'd0) flg_nxt.fail = 1'b1;
            end
            CK_COORD: begin
              if (!(acc_sh <= COORD_POS || acc_sh >= COORD_NEG)) flg_nxt.fail = 1'b1;
            end
            CK_DIM: begin
              if (acc_sh > DIM_MAX) flg_nxt.fail = 1'b1;
            end
            CK_LOCALE: begin
              if (acc_sh > {24'd0, max_loc_r}) flg_nxt.fail = 1'b1;
            end
            CK_SCALE: begin
              if (acc_sh < SCALE_MIN || acc_sh > SCALE_MAX) flg_nxt.fail = 1'b1;
            end
            CK_BOOL: begin
              if (acc_sh > 32'd1) flg_nxt.fail = 1'b1;
            end
            CK_KIND: begin
              saved_nxt = acc_sh[15:0];
              if (acc_sh > {24'd0, max_kind_r}) flg_nxt.fail = 1'b1;
            end
            CK_REASON: begin
              if (acc_sh > {24'd0, max_rsn_r}) flg_nxt.fail = 1'b1;
            end
            default: ;
          endcase
          if (cur.ft == FT_TXN && !(idnz_r || b != 8'd0)) flg_nxt.fail = 1'b1;
        end
      end
    end

    // advance to the first field that fits, failing each skipped one
    if (enter) begin
      done_nxt = 1'b1;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        se = slot_entry(kind_r == 4'd0 ? kind_nxt : kind_r, 4'(i));
        if (!found && 4'(i) >= start) begin
          case (se.ft)
            FT_TXN:          fits = f_txn;
            FT_U8:           fits = f_1;
            FT_U16, FT_TEXT: fits = f_2;
            FT_U32:          fits = f_4;
            default:         fits = f_8;
          endcase
          if (se.ft == FT_END) begin
            found = 1'b1;
          end else if (fits) begin
            found     = 1'b1;
            done_nxt  = 1'b0;
            slot_nxt  = 4'(i + 1);
            fidx_nxt  = '0;
            acc_nxt   = 32'd0;
            idnz_nxt  = 1'b0;
            u8s_nxt   = U_LEAD;
            trem_nxt  = 16'd0;
          end else begin
            flg_nxt.fail = 1'b1;
            if (se.ft == FT_TEXT) flg_nxt.txt_range = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    if (flg_nxt.overflow) code_c = ERR_LARGE;
    else if (cnt_nxt < 21'(HEADER_BYTES)) code_c = ERR_SMALL;
    else if (cnt_nxt > max_frame_r) code_c = ERR_LARGE;
    else if (flg_nxt.magic) code_c = ERR_MAGIC;
    else if (flg_nxt.version) code_c = ERR_VERSION;
    else if (flg_nxt.mtype) code_c = ERR_TYPE;
    else if (flg_nxt.reserved) code_c = ERR_RESERVED;
    else if (dlen_nxt != {11'd0, cnt_nxt - 21'(HEADER_BYTES)}) code_c = ERR_SIZE;
    else if (flg_nxt.fail) begin
      if (kind_nxt == 4'd3) code_c = ERR_RANGE;
      else if (flg_nxt.txt_utf8) code_c = ERR_UTF8;
      else if (flg_nxt.txt_range) code_c = ERR_RANGE;
      else code_c = ERR_MALFORM;
    end else if (flg_nxt.trail) code_c = ERR_MALFORM;
    else code_c = ERR_NONE;

    if (flg_nxt.overflow) bytes_c = COUNT_MAX;
    else if (cnt_nxt >= 21'(HEADER_BYTES)) bytes_c = cnt_nxt - 21'(HEADER_BYTES);
    else bytes_c = 21'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || last_acc) begin
      cnt_r   <= '0;
      slot_r  <= '0;
      done_r  <= 1'b0;
      fidx_r  <= '0;
      acc_r   <= '0;
      dlen_r  <= '0;
      kind_r  <= '0;
      trem_r  <= '0;
      u8s_r   <= U_LEAD;
      idnz_r  <= 1'b0;
      flg_r   <= '0;
      saved_r <= '0;
    end else if (in_acc) begin
      cnt_r   <= cnt_nxt;
      slot_r  <= slot_nxt;
      done_r  <= done_nxt;
      fidx_r  <= fidx_nxt;
      acc_r   <= acc_nxt;
      dlen_r  <= dlen_nxt;
      kind_r  <= kind_nxt;
      trem_r  <= trem_nxt;
      u8s_r   <= u8s_nxt;
      idnz_r  <= idnz_nxt;
      flg_r   <= flg_nxt;
      saved_r <= saved_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (last_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (last_acc) begin
      out_ok_r    <= (code_c == ERR_NONE);
      out_code_r  <= code_c;
      out_kind_r  <= kind_nxt;
      out_bytes_r <= bytes_c;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.frame_ok      = out_ok_r;
  assign out_ch.error_code    = out_code_r;
  assign out_ch.message_kind  = out_kind_r;
  assign out_ch.payload_bytes = out_bytes_r;

  a_verdict_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
    last_acc |=> out_valid_r && cnt_r == 21'd0)
    else $error("verdict or frame clear missing after last byte");

  a_ok_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_ok_r == (out_code_r == ERR_NONE)))
    else $error("frame_ok disagrees with error_code");

  a_header_no_parse: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < 21'(HEADER_BYTES) |-> !done_r && slot_r == 4'd0)
    else $error("payload parse state active during header");

  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= 4'(MAX_SLOTS))
    else $error("slot index out of range");

endmodule
